[design/etpq_pkg.sv]
// ----------------------------------------------------------------------------
// etpq_pkg: shared types and codes for the event time priority queue
// Holds the command and result item layouts, the stored entry layout, the
// per-cycle control word given to every cell, and the operation, kind and
// status codes.
// ----------------------------------------------------------------------------
package etpq_pkg;

    localparam int TIME_W = 32;
    localparam int TAG_W  = 16;
    localparam int OCC_W  = 5;
    localparam int STAT_W = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic KIND_ARRIVAL   = 1'b0;
    localparam logic KIND_DEPARTURE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic              operation;
        logic [TIME_W-1:0] event_time;
        logic              event_kind;
        logic [TAG_W-1:0]  event_tag;
    } command_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              head_valid;
        logic [TIME_W-1:0] head_time;
        logic              head_kind;
        logic [TAG_W-1:0]  head_tag;
        logic [OCC_W-1:0]  occupancy;
    } result_t;

    typedef struct packed {
        logic [TIME_W-1:0] event_time;
        logic              event_kind;
        logic [TAG_W-1:0]  event_tag;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic remove;
    } cell_ctrl_t;

endpackage

[design/etpq_cell.sv]
// ----------------------------------------------------------------------------
// etpq_cell: one slot of the sorted shift-register queue
// Compares the new event against its own entry and, on an insert, keeps its
// entry, takes the new event or takes its left neighbor's entry; on a remove
// it takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module etpq_cell (
    input  logic                clk,
    input  etpq_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  etpq_pkg::entry_t    new_entry,
    input  etpq_pkg::entry_t    left_entry,
    input  logic                left_behind,
    input  etpq_pkg::entry_t    right_entry,
    output etpq_pkg::entry_t    entry,
    output logic                behind
);

    etpq_pkg::entry_t entry_reg;
    etpq_pkg::entry_t entry_next;
    logic             goes_behind;

    // The new event goes behind an earlier entry, or behind an arrival of the
    // same time when it is itself a departure.
    always_comb
    begin
        goes_behind = (entry_reg.event_time < new_entry.event_time) ||
                      ((entry_reg.event_time == new_entry.event_time) &&
                       (new_entry.event_kind == etpq_pkg::KIND_DEPARTURE) &&
                       (entry_reg.event_kind == etpq_pkg::KIND_ARRIVAL));
    end

    assign behind = occupied && goes_behind;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.insert)
        begin
            priority if (behind)
            begin
                entry_next = entry_reg;
            end
            else if (left_behind)
            begin
                entry_next = new_entry;
            end
            else
            begin
                entry_next = left_entry;
            end
        end
        else if (ctrl.remove)
        begin
            entry_next = right_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

[design/event_time_priority_queue_unit.sv]
// ----------------------------------------------------------------------------
// event_time_priority_queue_unit: bounded event queue sorted by timestamp
// A row of QUEUE_DEPTH cells keeps the events in order, head in cell zero.
//
// A command item is taken at a rising edge with start high and busy low.
// busy stays low: the row of cells finishes an insert or a remove in the
// cycle it is taken, so one item may be given in every cycle.
// An insert puts the event behind every earlier event; at equal time a
// departure goes behind the arrivals and ahead of the departures, and an
// arrival goes ahead of all. A remove drops the head event.
// Each item yields one result item in the cycle after it is taken, shown for
// exactly one cycle while done is high: the status (ok, remove from empty,
// insert into full), the head event after the step and the occupancy.
// Throughput is one item per cycle, set by every cell's compare and shift.
// A refused insert or a remove from an empty queue changes nothing.
// Reset empties the queue and clears done; slot contents are not cleared.
// The receiver cannot hold results off, so none are ever stalled.
// ----------------------------------------------------------------------------
module event_time_priority_queue_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  etpq_pkg::command_t command,
    output logic               done,
    output etpq_pkg::result_t  result
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic                        done_reg;
    logic [etpq_pkg::STAT_W-1:0] status_reg;
    logic [etpq_pkg::STAT_W-1:0] status_next;

    logic                 accept;
    logic                 is_full;
    logic                 is_empty;
    etpq_pkg::cell_ctrl_t ctrl;
    etpq_pkg::entry_t     new_entry;
    etpq_pkg::entry_t     cell_entry [QUEUE_DEPTH];
    logic                 cell_behind [QUEUE_DEPTH];
    logic [31:0]          count_ext;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign is_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);

    assign new_entry.event_time = command.event_time;
    assign new_entry.event_kind = command.event_kind;
    assign new_entry.event_tag  = command.event_tag;

    always_comb
    begin
        ctrl        = '0;
        count_next  = count_reg;
        status_next = status_reg;
        if (accept)
        begin
            status_next = etpq_pkg::ST_OK;
            unique case (command.operation)
                etpq_pkg::OP_INSERT:
                begin
                    if (is_full)
                    begin
                        status_next = etpq_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctrl.insert = 1'b1;
                        count_next  = count_reg + 1'b1;
                    end
                end
                etpq_pkg::OP_REMOVE:
                begin
                    if (is_empty)
                    begin
                        status_next = etpq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        ctrl.remove = 1'b1;
                        count_next  = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    status_next = etpq_pkg::ST_OK;
                end
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            etpq_pkg::entry_t left_entry;
            etpq_pkg::entry_t right_entry;
            logic             left_behind;

            if (gi == 0)
            begin : g_first
                assign left_entry  = new_entry;
                assign left_behind = 1'b0;
            end
            else
            begin : g_inner_left
                assign left_entry  = cell_entry[gi-1];
                assign left_behind = cell_behind[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign right_entry = new_entry;
            end
            else
            begin : g_inner_right
                assign right_entry = cell_entry[gi+1];
            end

            etpq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (count_reg > CNT_W'(gi)),
                .new_entry   (new_entry),
                .left_entry  (left_entry),
                .left_behind (left_behind),
                .right_entry (right_entry),
                .entry       (cell_entry[gi]),
                .behind      (cell_behind[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= etpq_pkg::ST_OK;
        end
        else
        begin
            count_reg  <= count_next;
            done_reg   <= accept;
            status_reg <= status_next;
        end
    end

    assign count_ext = 32'(count_reg);
    assign done      = done_reg;

    always_comb
    begin
        result            = '0;
        result.status     = status_reg;
        result.head_valid = !is_empty;
        result.occupancy  = count_ext[etpq_pkg::OCC_W-1:0];
        if (!is_empty)
        begin
            result.head_time = cell_entry[0].event_time;
            result.head_kind = cell_entry[0].event_kind;
            result.head_tag  = cell_entry[0].event_tag;
        end
    end

    a_count_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("Stored count exceeds the queue depth.");

    a_full_refused : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command.operation == etpq_pkg::OP_INSERT && is_full)
        |=> (done && result.status == etpq_pkg::ST_FULL && $stable(count_reg)))
        else $error("An insert into a full queue was not refused.");

    a_insert_grows : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command.operation == etpq_pkg::OP_INSERT && !is_full)
        |=> (count_reg == $past(count_reg) + 1'b1 && result.head_valid))
        else $error("An accepted insert did not add one event.");

    a_empty_remove : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command.operation == etpq_pkg::OP_REMOVE && is_empty)
        |=> (done && result.status == etpq_pkg::ST_EMPTY && !result.head_valid))
        else $error("A remove from an empty queue was not flagged.");

    a_one_result : assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("A result appeared without an accepted item.");

endmodule
